[rtl/mpqt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpqt_pkg
// Shared types and codes for the sorted-cell priority queue.
// ----------------------------------------------------------------------------
package mpqt_pkg;

  localparam int MARKS_W = 16;
  localparam int ROLL_W  = 16;
  localparam int TAG_W   = 64;
  localparam int MODE_W  = 2;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_PEEK   = 2'd1;
  localparam mode_t MODE_POP    = 2'd2;

  typedef struct packed {
    logic [MARKS_W-1:0] marks;
    logic [ROLL_W-1:0]  roll;
    logic [TAG_W-1:0]   tag;
  } rec_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic pop_en;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_DECIDE,
    ST_APPLY,
    ST_REPORT
  } state_t;

endpackage

[rtl/max_priority_queue_tiebreak.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_priority_queue_tiebreak
// Sorted row of cells holding records best first (higher marks, then lower roll).
// ----------------------------------------------------------------------------
// Each accepted word goes through the compare, decide, shift and report steps
// before out_valid is set; output stalls hold the report step. A new word is
// taken only in idle, once the row is through with the last one.
// Reset: synchronous, active low; the store comes up empty, no clearing pass.
// ----------------------------------------------------------------------------
module max_priority_queue_tiebreak #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mpqt_pkg::MODE_W-1:0]   in_mode,
  input  logic [mpqt_pkg::MARKS_W-1:0]  in_marks,
  input  logic [mpqt_pkg::ROLL_W-1:0]   in_roll,
  input  logic [mpqt_pkg::TAG_W-1:0]    in_name_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_is_empty,
  output logic                          out_dropped,
  output logic [mpqt_pkg::MARKS_W-1:0]  out_best_marks,
  output logic [mpqt_pkg::ROLL_W-1:0]   out_best_roll,
  output logic [mpqt_pkg::TAG_W-1:0]    out_best_name_tag
);
  import mpqt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t state_r, state_nxt;
  cell_ctrl_t ctrl;

  mode_t              mode_r;
  logic [MARKS_W-1:0] marks_r;
  logic [ROLL_W-1:0]  roll_r;
  logic [TAG_W-1:0]   tag_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic dup_r, full_r;
  logic take_in, load_out;

  logic out_valid_r;
  logic out_is_empty_r, out_dropped_r;
  logic [MARKS_W-1:0] out_marks_r;
  logic [ROLL_W-1:0]  out_roll_r;
  logic [TAG_W-1:0]   out_tag_r;

  rec_t cell_rec [CAPACITY];
  logic [CAPACITY-1:0] cell_ahead;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] occ;

  logic is_insert, is_pop;

  assign is_insert = (mode_r == MODE_INSERT);
  assign is_pop    = (mode_r == MODE_POP);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      rec_t left_rec, right_rec;
      logic left_ahead;

      assign occ[g] = (count_r > CNT_W'(g));

      if (g == 0) begin : g_first
        assign left_rec   = '0;
        assign left_ahead = 1'b0;
      end else begin : g_mid
        assign left_rec   = cell_rec[g-1];
        assign left_ahead = cell_ahead[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
        assign right_rec = '0;
      end else begin : g_body
        assign right_rec = cell_rec[g+1];
      end

      mpqt_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .key_marks  (marks_r),
        .key_roll   (roll_r),
        .key_tag    (tag_r),
        .occ        (occ[g]),
        .left_rec   (left_rec),
        .left_ahead (left_ahead),
        .right_rec  (right_rec),
        .rec        (cell_rec[g]),
        .ahead      (cell_ahead[g]),
        .eq         (cell_eq[g])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CMP;
      ST_CMP:    state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_APPLY;
      ST_APPLY:  state_nxt = ST_REPORT;
      ST_REPORT: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    take_in     = 1'b0;
    load_out    = 1'b0;
    ctrl        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        take_in  = in_valid;
      end
      ST_CMP: begin
        ctrl.cmp_en = 1'b1;
      end
      ST_DECIDE: begin
      end
      ST_APPLY: begin
        ctrl.ins_en = is_insert && !dup_r && !full_r;
        ctrl.pop_en = is_pop;
      end
      ST_REPORT: begin
        load_out = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop_en && (count_r != '0)) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      mode_r  <= in_mode;
      marks_r <= in_marks;
      roll_r  <= in_roll;
      tag_r   <= in_name_tag;
    end
    if (state_r == ST_DECIDE) begin
      dup_r  <= |cell_eq;
      full_r <= (count_r == CNT_W'(CAPACITY));
    end
    if (load_out) begin
      out_is_empty_r <= (count_r == '0);
      out_dropped_r  <= is_insert && !dup_r && full_r;
      out_marks_r    <= (count_r == '0) ? '0 : cell_rec[0].marks;
      out_roll_r     <= (count_r == '0) ? '0 : cell_rec[0].roll;
      out_tag_r      <= (count_r == '0) ? '0 : cell_rec[0].tag;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_empty      = out_is_empty_r;
  assign out_dropped       = out_dropped_r;
  assign out_best_marks    = out_marks_r;
  assign out_best_roll     = out_roll_r;
  assign out_best_name_tag = out_tag_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_only_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_APPLY) |=> $stable(count_r))
    else $error("entry count changed outside apply step");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CMP))
    else $error("accepted word did not start compare");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && (count_r >= CNT_W'(2))) |->
      ((cell_rec[0].marks > cell_rec[1].marks) ||
       ((cell_rec[0].marks == cell_rec[1].marks) &&
        (cell_rec[0].roll < cell_rec[1].roll))))
    else $error("head cells out of order");

  a_dropped_insert: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && is_insert && !dup_r && full_r |-> (count_r == CNT_W'(CAPACITY)))
    else $error("drop reported while store not full");

endmodule

[rtl/mpqt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpqt_cell
// One slot of the sorted row: compares the key, shifts toward either neighbor.
// ----------------------------------------------------------------------------
module mpqt_cell (
  input  logic                          clk,
  input  mpqt_pkg::cell_ctrl_t          ctrl,
  input  logic [mpqt_pkg::MARKS_W-1:0]  key_marks,
  input  logic [mpqt_pkg::ROLL_W-1:0]   key_roll,
  input  logic [mpqt_pkg::TAG_W-1:0]    key_tag,
  input  logic                          occ,
  input  mpqt_pkg::rec_t                left_rec,
  input  logic                          left_ahead,
  input  mpqt_pkg::rec_t                right_rec,
  output mpqt_pkg::rec_t                rec,
  output logic                          ahead,
  output logic                          eq
);
  import mpqt_pkg::*;

  rec_t rec_r, rec_nxt;
  logic ahead_r, ahead_nxt;
  logic eq_r, eq_nxt;
  logic key_gt;
  logic key_eq;

  assign key_gt = (key_marks > rec_r.marks) ||
                  ((key_marks == rec_r.marks) && (key_roll < rec_r.roll));
  assign key_eq = (key_marks == rec_r.marks) && (key_roll == rec_r.roll);

  always_comb begin
    ahead_nxt = ahead_r;
    eq_nxt    = eq_r;
    if (ctrl.cmp_en) begin
      ahead_nxt = !occ || key_gt;
      eq_nxt    = occ && key_eq;
    end
  end

  always_comb begin
    rec_nxt = rec_r;
    if (ctrl.ins_en) begin
      if (left_ahead) begin
        rec_nxt = left_rec;
      end else if (ahead_r) begin
        rec_nxt.marks = key_marks;
        rec_nxt.roll  = key_roll;
        rec_nxt.tag   = key_tag;
      end
    end else if (ctrl.pop_en) begin
      rec_nxt = right_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r   <= rec_nxt;
    ahead_r <= ahead_nxt;
    eq_r    <= eq_nxt;
  end

  assign rec   = rec_r;
  assign ahead = ahead_r;
  assign eq    = eq_r;

endmodule
